// ----- rtl/pngunf_pkg.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter package
// Shared constants, register indexes, filter codes and the payload structs
// of the PNG scanline unfilter block.
// ----------------------------------------------------------------------------
package pngunf_pkg;

    // Largest image width in pixels that the line store is sized for.
    localparam int MAX_WIDTH   = 4096;
    localparam int STORE_DEPTH = MAX_WIDTH * 4;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    // A column counter must be able to hold the full row length itself.
    localparam int COL_W       = $clog2(STORE_DEPTH + 1);

    // Field widths of the configuration registers.
    localparam int WIDTH_W     = 13;
    localparam int HEIGHT_W    = 16;
    localparam int CHAN_W      = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_IMAGE_WIDTH    = 2'd0,
        REG_IMAGE_HEIGHT   = 2'd1,
        REG_PIXEL_CHANNELS = 2'd2
    } cfg_reg_t;

    // Row filter types as coded in the stream.
    typedef enum logic [2:0] {
        FILT_NONE  = 3'd0,
        FILT_SUB   = 3'd1,
        FILT_UP    = 3'd2,
        FILT_AVG   = 3'd3,
        FILT_PAETH = 3'd4
    } filter_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_image;
    } in_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last_in_row;
        logic       last_in_image;
        logic       bad_filter;
    } out_item_t;

endpackage

// ----- rtl/png_scanline_unfilter_rgba_unit.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter with RGBA expansion
// Undoes the five PNG row filters on an inflated 8-bit, non-interlaced byte
// stream and emits one RGBA pixel per completed pixel.
// ----------------------------------------------------------------------------
// The block takes one byte per transfer and sustains one transfer per clock
// cycle while the skid register is empty, also on single-channel Paeth rows,
// where each byte depends on the byte just before it: that left-neighbor
// feedback is combinational. The previous row lives in a single 16384 x 8
// line store with one write and one registered read port; the entry for the
// next column is fetched ahead, so the store never holds off the input. A
// finished pixel goes to the output holding register, or to the skid
// register behind it while the output stalls, so one more pixel is still
// finished while a pixel waits for the consumer. The store needs no clearing
// after reset: the row above the first row of an image reads as zero by rule.
module png_scanline_unfilter_rgba_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [pngunf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pngunf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  pngunf_pkg::in_item_t                 in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pngunf_pkg::out_item_t                out_data
);
    import pngunf_pkg::*;

    // Configuration registers.
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [CHAN_W-1:0]   chan_cfg_reg;

    // Row and pixel state.
    logic [31:0]         left_reg,    left_next;
    logic [31:0]         ul_reg,      ul_next;
    logic [23:0]         part_reg,    part_next;
    filter_t             filter_reg,  filter_next;
    logic [COL_W-1:0]    col_reg,     col_next;
    logic [1:0]          mod3_reg,    mod3_next;
    logic [15:0]         row_reg,     row_next;
    logic                await_reg,   await_next;
    logic                fault_reg,   fault_next;

    // Output holding register and skid register.
    out_item_t           out_reg;
    logic                out_valid_reg, out_valid_next;
    out_item_t           skid_reg;
    logic                skid_valid_reg, skid_valid_next;

    // Line store.
    logic [7:0]          store_mem [STORE_DEPTH];
    logic [7:0]          rd_data_reg;
    logic [STORE_AW-1:0] rd_addr;
    logic                wr_en;

    // Effective configuration.
    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;
    logic [2:0]          eff_ch;
    logic [COL_W-1:0]    stride;

    // Datapath.
    logic                accept;
    logic [1:0]          k_idx;
    logic [1:0]          mod3_inc;
    logic [4:0]          shift;
    logic [7:0]          a_val, b_val, c_val, v_val;
    logic [8:0]          avg_sum;
    logic signed [9:0]   pa, pb, pc;
    logic [7:0]          paeth_val;
    logic [31:0]         pix;
    logic [COL_W-1:0]    col_inc;
    logic                row_done;
    logic                produce;
    out_item_t           res;

    // ------------------------------------------------------------------
    // Configuration port.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_W'(1);
            height_reg   <= HEIGHT_W'(1);
            chan_cfg_reg <= CHAN_W'(4);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:    width_reg    <= cfg_wdata[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT:   height_reg   <= cfg_wdata[HEIGHT_W-1:0];
                REG_PIXEL_CHANNELS: chan_cfg_reg <= cfg_wdata[CHAN_W-1:0];
                default:            ;
            endcase
        end
    end

    // Out-of-range settings are clamped into their legal ranges.
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WIDTH_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            eff_w = WIDTH_W'(MAX_WIDTH);
        else
            eff_w = width_reg;

        eff_h = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;

        if (chan_cfg_reg == '0)
            eff_ch = 3'd1;
        else if (chan_cfg_reg > 3'd4)
            eff_ch = 3'd4;
        else
            eff_ch = chan_cfg_reg;
    end

    assign stride = COL_W'(eff_w) * COL_W'(eff_ch);

    // The channel of the current byte is the column modulo the channel
    // count. The column modulo three is kept as a counter beside the column,
    // so a channel count changed in the middle of an image still picks the
    // right channel.
    always_comb
    begin
        case (eff_ch)
            3'd4:    k_idx = col_reg[1:0];
            3'd3:    k_idx = mod3_reg;
            3'd2:    k_idx = {1'b0, col_reg[0]};
            default: k_idx = 2'd0;
        endcase
    end

    assign mod3_inc = (mod3_reg == 2'd2) ? 2'd0 : mod3_reg + 2'd1;

    // ------------------------------------------------------------------
    // Unfilter datapath. Sample bytes are never the first byte of an image,
    // so the neighbors come straight from the state registers.
    // ------------------------------------------------------------------
    assign accept = in_valid && in_ready;
    assign shift  = {k_idx, 3'b000};
    assign a_val  = left_reg[shift +: 8];
    assign c_val  = ul_reg[shift +: 8];
    assign b_val  = (row_reg != '0) ? rd_data_reg : 8'd0;

    assign avg_sum = {1'b0, a_val} + {1'b0, b_val};

    // With p = a + b - c the three Paeth distances reduce to these terms.
    assign pa = $signed({2'b00, b_val}) - $signed({2'b00, c_val});
    assign pb = $signed({2'b00, a_val}) - $signed({2'b00, c_val});
    assign pc = pa + pb;

    always_comb
    begin
        logic [9:0] da, db, dc;
        da = pa[9] ? 10'(-pa) : 10'(pa);
        db = pb[9] ? 10'(-pb) : 10'(pb);
        dc = pc[9] ? 10'(-pc) : 10'(pc);
        if (da <= db && da <= dc)
            paeth_val = a_val;
        else if (db <= dc)
            paeth_val = b_val;
        else
            paeth_val = c_val;
    end

    always_comb
    begin
        case (filter_reg)
            FILT_SUB:   v_val = in_data.data_byte + a_val;
            FILT_UP:    v_val = in_data.data_byte + b_val;
            FILT_AVG:   v_val = in_data.data_byte + avg_sum[8:1];
            FILT_PAETH: v_val = in_data.data_byte + paeth_val;
            default:    v_val = in_data.data_byte;
        endcase
    end

    assign pix      = {8'd0, part_reg} | ({24'd0, v_val} << shift);
    assign col_inc  = col_reg + COL_W'(1);
    assign row_done = (col_inc >= stride);

    // ------------------------------------------------------------------
    // Sequencing of filter bytes, samples and row ends.
    // ------------------------------------------------------------------
    always_comb
    begin
        left_next   = left_reg;
        ul_next     = ul_reg;
        part_next   = part_reg;
        filter_next = filter_reg;
        col_next    = col_reg;
        mod3_next   = mod3_reg;
        row_next    = row_reg;
        await_next  = await_reg;
        fault_next  = fault_reg;
        wr_en       = 1'b0;
        produce     = 1'b0;
        res         = '0;

        if (accept)
        begin
            if (in_data.first_of_image)
            begin
                left_next   = '0;
                ul_next     = '0;
                part_next   = '0;
                filter_next = FILT_NONE;
                col_next    = '0;
                mod3_next   = '0;
                row_next    = '0;
                await_next  = 1'b1;
                fault_next  = 1'b0;
            end

            // An image start is always taken as a filter byte.
            if (in_data.first_of_image || (!fault_reg && row_reg < eff_h))
            begin
                if (in_data.first_of_image || await_reg)
                begin
                    if (in_data.data_byte > 8'(FILT_PAETH))
                    begin
                        fault_next     = 1'b1;
                        produce        = 1'b1;
                        res.bad_filter = 1'b1;
                    end
                    else
                    begin
                        filter_next = filter_t'(in_data.data_byte[2:0]);
                        await_next  = 1'b0;
                        col_next    = '0;
                        mod3_next   = '0;
                        left_next   = '0;
                        ul_next     = '0;
                        part_next   = '0;
                    end
                end
                else if (col_reg >= stride)
                begin
                    // The row length shrank under the column: close the row.
                    row_next   = (row_reg == 16'hFFFF) ? row_reg : row_reg + 16'd1;
                    col_next   = '0;
                    mod3_next  = '0;
                    await_next = 1'b1;
                end
                else
                begin
                    wr_en           = 1'b1;
                    ul_next[shift +: 8] = b_val;
                    col_next        = col_inc;
                    mod3_next       = mod3_inc;

                    if ({1'b0, k_idx} + 3'd1 < eff_ch)
                    begin
                        part_next[shift +: 8] = v_val;
                    end
                    else
                    begin
                        left_next = pix;
                        part_next = '0;
                        produce   = 1'b1;
                        case (eff_ch)
                            3'd4:
                            begin
                                res.red   = pix[7:0];
                                res.green = pix[15:8];
                                res.blue  = pix[23:16];
                                res.alpha = pix[31:24];
                            end
                            3'd3:
                            begin
                                res.red   = pix[7:0];
                                res.green = pix[15:8];
                                res.blue  = pix[23:16];
                                res.alpha = ALPHA_OPAQUE;
                            end
                            3'd2:
                            begin
                                res.red   = pix[7:0];
                                res.green = pix[7:0];
                                res.blue  = pix[7:0];
                                res.alpha = pix[15:8];
                            end
                            default:
                            begin
                                res.red   = pix[7:0];
                                res.green = pix[7:0];
                                res.blue  = pix[7:0];
                                res.alpha = ALPHA_OPAQUE;
                            end
                        endcase
                        if (row_done)
                        begin
                            res.last_in_row   = 1'b1;
                            res.last_in_image = ({1'b0, row_reg} + 17'd1 == {1'b0, eff_h});
                        end
                    end

                    // A row that ends on an incomplete pixel gives no result.
                    if (row_done)
                    begin
                        row_next   = (row_reg == 16'hFFFF) ? row_reg : row_reg + 16'd1;
                        col_next   = '0;
                        mod3_next  = '0;
                        await_next = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg   <= '0;
            ul_reg     <= '0;
            part_reg   <= '0;
            filter_reg <= FILT_NONE;
            col_reg    <= '0;
            mod3_reg   <= '0;
            row_reg    <= '0;
            await_reg  <= 1'b1;
            fault_reg  <= 1'b0;
        end
        else
        begin
            left_reg   <= left_next;
            ul_reg     <= ul_next;
            part_reg   <= part_next;
            filter_reg <= filter_next;
            col_reg    <= col_next;
            mod3_reg   <= mod3_next;
            row_reg    <= row_next;
            await_reg  <= await_next;
            fault_reg  <= fault_next;
        end
    end

    // ------------------------------------------------------------------
    // Line store. The read port always fetches the entry of the column that
    // comes next, so its data is ready when that column's byte arrives. A
    // write to the very entry being fetched (a one-byte row) is forwarded.
    // ------------------------------------------------------------------
    assign rd_addr = col_next[STORE_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[col_reg[STORE_AW-1:0]] <= v_val;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (col_reg[STORE_AW-1:0] == rd_addr))
            rd_data_reg <= v_val;
        else
            rd_data_reg <= store_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Output holding register with a skid register behind it.
    // ------------------------------------------------------------------
    assign in_ready = !skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            out_valid_next  = skid_valid_reg || produce;
            skid_valid_next = 1'b0;
        end
        else if (produce)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (produce)
            skid_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- rtl/pngunf_checker.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter port checker
// Watches the ports of the unfilter block and flags result patterns and
// handshake behavior that the block must never show.
// ----------------------------------------------------------------------------
module pngunf_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input pngunf_pkg::in_item_t  in_data,
    input logic                  out_valid,
    input logic                  out_ready,
    input pngunf_pkg::out_item_t out_data
);
    import pngunf_pkg::*;

    // An error result carries no pixel and no end marks.
    a_bad_filter_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.bad_filter |->
            out_data.red == 8'd0 && out_data.green == 8'd0 &&
            out_data.blue == 8'd0 && out_data.alpha == 8'd0 &&
            !out_data.last_in_row && !out_data.last_in_image)
        else $error("error result carries pixel data or end marks");

    // The last pixel of an image also ends its row.
    a_image_end_is_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.last_in_image |-> out_data.last_in_row)
        else $error("image end without row end");

    // Input is only held off while a result is waiting to be taken.
    a_backpressure_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    // A stalled result stays on the port unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or vanished while stalled");

    // Once the output drains, input is accepted again in the next cycle.
    a_ready_returns: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |=> in_ready)
        else $error("input still stalled after the output drained");

endmodule

bind png_scanline_unfilter_rgba_unit pngunf_checker u_pngunf_checker (.*);

// ----- tb/sv/png_scanline_unfilter_rgba_unit_tb.sv -----
// ----------------------------------------------------------------------------
// PNG scanline unfilter testbench
// Streams filtered PNG rows into the unfilter block under random handshake
// pressure, predicts every RGBA pixel and error result in step with each
// accepted byte, and checks each output transfer field by field in order.
// ----------------------------------------------------------------------------
module png_scanline_unfilter_rgba_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pngunf_pkg::*;

    // Cycles to let pass after every queued byte is taken and the last expected
    // result has come, before touching the registers.
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_LIMIT   = 100000;
    // Length of the one long receiver hold-off that backs up the block.
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_BYTES  = 950;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;

    png_scanline_unfilter_rgba_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Testbench copy of the registers and of the unfilter state.
    // ------------------------------------------------------------------------
    logic [WIDTH_W-1:0]  cfg_width = 13'd1;
    logic [HEIGHT_W-1:0] cfg_height = 16'd1;
    logic [CHAN_W-1:0]   cfg_chan = 3'd4;

    bit   [7:0]  prev_row [STORE_DEPTH];
    logic [31:0] left_px = '0;
    logic [31:0] upleft_px = '0;
    logic [23:0] partial_px = '0;
    filter_t     row_filter = FILT_NONE;
    int unsigned col_pos = 0;
    logic [15:0] row_num = '0;
    logic        want_filter = 1'b1;
    logic        fault_seen = 1'b0;

    in_item_t    pending_bytes[$];
    out_item_t   pixel_expect[$];

    int unsigned bytes_queued = 0;
    int unsigned bytes_accepted = 0;
    int unsigned frame_bytes = 0;
    int unsigned frames_queued = 0;
    int unsigned cfg_writes = 0;
    int unsigned pixels_checked = 0;
    int unsigned faults_checked = 0;
    int unsigned input_stalls = 0;
    int unsigned mismatches = 0;

    // Idling switches, flipped by the stimulus between phases.
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_arm = 1'b0;

    int unsigned src_gap;
    int unsigned sink_gap;
    int unsigned hold_count;

    // Out-of-range register values are clamped the same way the block does.
    function automatic int unsigned chan_count();
        if (cfg_chan == 0)
            return 1;
        if (cfg_chan > 4)
            return 4;
        return cfg_chan;
    endfunction

    function automatic int unsigned row_len();
        int unsigned w;
        w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width);
        return w * chan_count();
    endfunction

    function automatic int unsigned frame_rows();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    function automatic void close_row();
        if (row_num != 16'hFFFF)
            row_num++;
        col_pos = 0;
        want_filter = 1'b1;
    endfunction

    // Advances the unfilter state by one accepted byte and queues the pixel
    // or error result that the byte produces, if any.
    task automatic defilter_byte(input in_item_t item);
        int unsigned ch, len, x, k, sh;
        int          ia, ib, ic, p, pa, pb, pc;
        logic [7:0]  a, b, c, v, pred;
        logic [31:0] pix;
        out_item_t   px;

        ch = chan_count();
        len = row_len();
        if (item.first_of_image)
        begin
            row_num = '0;
            col_pos = 0;
            want_filter = 1'b1;
            fault_seen = 1'b0;
            row_filter = FILT_NONE;
            left_px = '0;
            upleft_px = '0;
            partial_px = '0;
        end
        // After a fault or past the last row everything is ignored.
        if (fault_seen || row_num >= frame_rows())
            return;

        if (want_filter)
        begin
            if (item.data_byte > FILT_PAETH)
            begin
                fault_seen = 1'b1;
                px = '0;
                px.bad_filter = 1'b1;
                pixel_expect.insert(pixel_expect.size(), px);
                return;
            end
            row_filter = filter_t'(item.data_byte[2:0]);
            want_filter = 1'b0;
            col_pos = 0;
            left_px = '0;
            upleft_px = '0;
            partial_px = '0;
            return;
        end

        x = col_pos;
        // The row shrank under us: the byte is dropped and the row closes.
        if (x >= len)
        begin
            close_row();
            return;
        end
        k = x % ch;
        sh = 8 * k;
        a = left_px[sh +: 8];
        b = (row_num != 0) ? prev_row[x] : 8'd0;
        c = upleft_px[sh +: 8];

        case (row_filter)
            FILT_SUB:   pred = a;
            FILT_UP:    pred = b;
            FILT_AVG:   pred = 8'((9'(a) + 9'(b)) >> 1);
            FILT_PAETH:
            begin
                ia = int'(a);
                ib = int'(b);
                ic = int'(c);
                p = ia + ib - ic;
                pa = (p > ia) ? p - ia : ia - p;
                pb = (p > ib) ? p - ib : ib - p;
                pc = (p > ic) ? p - ic : ic - p;
                if (pa <= pb && pa <= pc)
                    pred = a;
                else if (pb <= pc)
                    pred = b;
                else
                    pred = c;
            end
            default:    pred = 8'd0;
        endcase
        v = item.data_byte + pred;

        prev_row[x] = v;
        upleft_px[sh +: 8] = b;
        col_pos = x + 1;

        if (k + 1 < ch)
        begin
            partial_px[sh +: 8] = v;
            if (x + 1 >= len)
                close_row();
            return;
        end

        pix = {8'd0, partial_px} | (32'(v) << sh);
        left_px = pix;
        partial_px = '0;

        // Grey is copied to all three colors; missing alpha is opaque.
        px = '0;
        px.red = pix[7:0];
        px.green = (ch >= 3) ? pix[15:8] : pix[7:0];
        px.blue = (ch >= 3) ? pix[23:16] : pix[7:0];
        px.alpha = (ch == 4) ? pix[31:24] : ((ch == 2) ? pix[15:8] : ALPHA_OPAQUE);
        if (x + 1 >= len)
        begin
            px.last_in_row = 1'b1;
            px.last_in_image = (32'(row_num) + 1 == frame_rows());
            close_row();
        end
        pixel_expect.insert(pixel_expect.size(), px);
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued bytes, holds each one until its transfer, and
    // feeds every transfer to the predictor.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                defilter_byte(in_data);
                bytes_accepted++;
            end
            if (in_valid && !in_ready)
                input_stalls++;
            if (!in_valid || in_ready)
            begin
                if (src_gap != 0)
                begin
                    in_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end
                else if (pending_bytes.size() != 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_bytes.pop_front();
                    if (src_idle_on && $urandom_range(0, 3) == 0)
                        src_gap <= $urandom_range(1, 3);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: throttles out_ready and checks every result transfer against
    // the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap <= 0;
            hold_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pixel_expect.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    mismatches++;
                end
                else
                begin
                    out_item_t want;
                    want = pixel_expect.pop_front();
                    check_field("red", want.red, out_data.red);
                    check_field("green", want.green, out_data.green);
                    check_field("blue", want.blue, out_data.blue);
                    check_field("alpha", want.alpha, out_data.alpha);
                    check_field("last_in_row", want.last_in_row, out_data.last_in_row);
                    check_field("last_in_image", want.last_in_image, out_data.last_in_image);
                    check_field("bad_filter", want.bad_filter, out_data.bad_filter);
                    if (want.bad_filter)
                        faults_checked++;
                    else
                        pixels_checked++;
                end
            end

            if (hold_arm && hold_count < HOLD_CYCLES)
            begin
                out_ready <= 1'b0;
                hold_count <= hold_count + 1;
            end
            else if (sink_gap != 0)
            begin
                out_ready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end
            else if (sink_idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                sink_gap <= $urandom_range(0, 2);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:    cfg_width = value[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT:   cfg_height = value[HEIGHT_W-1:0];
            REG_PIXEL_CHANNELS: cfg_chan = value[CHAN_W-1:0];
            default:            ;
        endcase
        cfg_writes++;
    endtask

    function automatic void push_byte(input logic [7:0] d, input logic first);
        in_item_t it;
        it.data_byte = d;
        it.first_of_image = first;
        pending_bytes.insert(pending_bytes.size(), it);
        bytes_queued++;
    endfunction

    // Queues one image for the current registers. A bad filter byte replaces
    // the filter of row bad_row and ends the image there; cut_at truncates
    // the image after that many bytes. Negative values disable either.
    task automatic queue_frame(input int bad_row, input int cut_at);
        int         len, total, i, r;
        logic [7:0] d;

        len = row_len();
        total = frame_rows() * (len + 1);
        frames_queued++;
        for (i = 0; i < total; i++)
        begin
            if (cut_at >= 0 && i == cut_at)
                break;
            r = i / (len + 1);
            if (i % (len + 1) == 0)
            begin
                if (r == bad_row)
                begin
                    push_byte(8'($urandom_range(5, 255)), i == 0);
                    break;
                end
                d = 8'($urandom_range(FILT_NONE, FILT_PAETH));
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       d = 8'h00;
                    1:       d = 8'hFF;
                    default: d = 8'($urandom);
                endcase
            end
            push_byte(d, i == 0);
            frame_bytes++;
        end
    endtask

    // Waits until every queued byte is taken and every expected result has
    // come, then lets the block settle before registers may change.
    task automatic wait_idle();
        int unsigned waited;
        waited = 0;
        while ((bytes_accepted != bytes_queued || pixel_expect.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (bytes_accepted != bytes_queued)
        begin
            $error("%0d queued bytes were never taken", bytes_queued - bytes_accepted);
            mismatches++;
        end
        if (pixel_expect.size() != 0)
        begin
            $error("%0d expected results never arrived", pixel_expect.size());
            mismatches += pixel_expect.size();
            pixel_expect.delete();
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned random_start;
        int          nframes, kind, total, f, j;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // One RGBA pixel with the reset registers, extreme samples, then a
        // byte after the image is complete, which must be ignored.
        push_byte(FILT_NONE, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'h55, 1'b0);
        wait_idle();

        // Bad filter types at both ends of the range; the byte between them
        // is discarded and the second image start clears the fault.
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h05, 1'b1);
        wait_idle();

        // Zero in every register acts as a single grey pixel, one row.
        write_reg(REG_IMAGE_WIDTH, 16'd0);
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        write_reg(REG_PIXEL_CHANNELS, 16'd0);
        push_byte(FILT_SUB, 1'b1);
        push_byte(8'hC3, 1'b0);
        wait_idle();

        // Grey plus alpha, Paeth on the first row, average on the second.
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        write_reg(REG_PIXEL_CHANNELS, 16'd2);
        push_byte(FILT_PAETH, 1'b1);
        push_byte(8'h10, 1'b0);
        push_byte(8'h20, 1'b0);
        push_byte(8'h30, 1'b0);
        push_byte(8'h40, 1'b0);
        push_byte(FILT_AVG, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'hFF, 1'b0);
        wait_idle();

        // A channel count above four, then the width shrinks mid-row while a
        // pixel is half built: the next byte is dropped and closes the row.
        write_reg(REG_PIXEL_CHANNELS, 16'd7);
        push_byte(FILT_UP, 1'b1);
        for (j = 1; j <= 6; j++)
            push_byte(8'(j * 8'h11), 1'b0);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        push_byte(8'h77, 1'b0);
        push_byte(FILT_UP, 1'b0);
        push_byte(8'h01, 1'b0);
        push_byte(8'h02, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(8'h04, 1'b0);
        wait_idle();

        // Widest register value clamps to the largest width the line store is
        // sized for, with the tallest height: the opening stretch of one long grey row.
        write_reg(REG_IMAGE_WIDTH, 16'h1FFF);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        write_reg(REG_PIXEL_CHANNELS, 16'd1);
        queue_frame(-1, 60);
        wait_idle();

        // The receiver stops for a long stretch while the sender keeps
        // offering, so the output side fills and the input backs up.
        write_reg(REG_IMAGE_WIDTH, 16'd16);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        hold_arm = 1'b1;
        queue_frame(-1, -1);
        wait_idle();

        // Random phases: mostly well-formed small images, with bad filters,
        // truncated images and trailing junk mixed in.
        random_start = frame_bytes;
        while (frame_bytes - random_start < RANDOM_BYTES)
        begin
            case ($urandom_range(0, 9))
                0:       write_reg(REG_IMAGE_WIDTH, 16'd0);
                1:       write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(9, 40)));
                default: write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(1, 8)));
            endcase
            if ($urandom_range(0, 11) == 0)
                write_reg(REG_IMAGE_HEIGHT, 16'd0);
            else
                write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(1, 4)));
            case ($urandom_range(0, 11))
                0:       write_reg(REG_PIXEL_CHANNELS, 16'd0);
                1:       write_reg(REG_PIXEL_CHANNELS, 16'($urandom_range(5, 7)));
                default: write_reg(REG_PIXEL_CHANNELS, 16'($urandom_range(1, 4)));
            endcase

            // The tail of the run goes at full rate on both sides.
            if (frame_bytes - random_start > RANDOM_BYTES - 150)
            begin
                src_idle_on = 1'b0;
                sink_idle_on = 1'b0;
            end
            else
            begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end

            nframes = $urandom_range(1, 3);
            for (f = 0; f < nframes; f++)
            begin
                kind = $urandom_range(0, 9);
                total = frame_rows() * (row_len() + 1);
                if (kind == 0)
                    queue_frame($urandom_range(0, frame_rows() - 1), -1);
                else if (kind == 1)
                    queue_frame(-1, $urandom_range(1, total - 1));
                else
                    queue_frame(-1, -1);
                if (kind <= 2)
                begin
                    for (j = $urandom_range(0, 4); j > 0; j--)
                        push_byte(8'($urandom), 1'b0);
                end
            end
            wait_idle();
        end

        $display("Run covered %0d byte transfers in %0d images across %0d register writes,",
                 bytes_accepted, frames_queued, cfg_writes);
        $display("checking %0d pixels and %0d bad-filter results; input stalled %0d cycles.",
                 pixels_checked, faults_checked, input_stalls);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/pngunf_pkg.sv
rtl/png_scanline_unfilter_rgba_unit.sv
rtl/pngunf_checker.sv
tb/sv/png_scanline_unfilter_rgba_unit_tb.sv
